// ===== hdl/cle_pkg.sv =====
package cle_pkg;
	typedef enum logic [2:0] {
		FN_INS_FRONT = 3'd0,
		FN_INS_END   = 3'd1,
		FN_DEL_FRONT = 3'd2,
		FN_DEL_END   = 3'd3,
		FN_INS_AT    = 3'd4,
		FN_DEL_AT    = 3'd5,
		FN_READ_ALL  = 3'd6,
		FN_NOP       = 3'd7
	} func_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_DECIDE,
		S_WALK,
		S_VICT,
		S_WR1,
		S_WR2,
		S_READ,
		S_EMIT,
		S_RESP
	} state_t;

	localparam int unsigned MAX_RESULTS = 32;
endpackage

// ===== hdl/cle_stream_if.sv =====
interface cle_stream_if #(parameter int unsigned W = 8);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== hdl/circular_list_engine.sv =====
// channel | direction | payload bits
// req     | in        | func[42:40] item_value[39:8] position[7:0]
// rsp     | out       | status[41:40] element_count[39:34] has_element[33]
//         |           | out_value[32:1] last[0]
// After a request is taken, an error or unused code goes from decide straight to the response;
// front/end inserts write in WR1 and WR2 (WR1 only on an empty list); deletes and insert-at
// walk the chain (steps = position-2, count-2 for delete end) after decide, then write in WR1
// and WR2 (WR1 only for a delete on a one-element list), with a victim read before them for delete-at.
// Read-all passes through the read, load and handshake states for each element. After the last
// response the engine returns to idle. Reset chains the free list, taking no request meanwhile.
// A stalled response holds the engine in place.
module circular_list_engine import cle_pkg::*; #(
	parameter int unsigned CAPACITY = 32
) (
	input  logic clk,
	input  logic arst_n,
	cle_stream_if.sink   req,
	cle_stream_if.source rsp
);
	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	logic [31:0]   value_mem [CAPACITY];
	logic [AW-1:0] link_mem  [CAPACITY];

	state_t        state_q, state_nx;
	logic [AW-1:0] init_q, front_q, end_q, free_q, free_nx_q, p_q, node_q, nxt_q;
	logic [CW-1:0] len_q, steps_q, w_q;
	func_t         func_q, op_q;
	logic [31:0]   val_q;
	logic [7:0]    pos_q;
	logic [5:0]    emit_q;
	status_t       sts_q;
	logic          rhas_q, rlast_q;
	logic [31:0]   rval_q;
	logic [AW-1:0] link_rd;
	logic [31:0]   val_rd;

	// memory ports
	logic          l_we, v_we;
	logic [AW-1:0] l_wa, l_ra, v_wa, v_ra;
	logic [AW-1:0] l_wd;

	always_ff @(posedge clk) begin
		if (l_we) link_mem[l_wa] <= l_wd;
		if (v_we) value_mem[v_wa] <= val_q;
		link_rd <= link_mem[l_ra];
		val_rd  <= value_mem[v_ra];
	end

	logic       full, empty, one, walk_done, ins_op, wr1_last;
	logic [8:0] len9, pos9;
	logic [6:0] rd_cnt;
	assign full      = (len_q >= CW'(CAPACITY));
	assign empty     = (len_q == '0);
	assign one       = (len_q == CW'(1));
	assign walk_done = (w_q == steps_q);
	assign len9      = 9'(len_q);
	assign pos9      = {1'b0, pos_q};
	assign rd_cnt    = (7'(len_q) < 7'(MAX_RESULTS)) ? 7'(len_q) : 7'(MAX_RESULTS);
	assign ins_op    = (op_q == FN_INS_FRONT) || (op_q == FN_INS_END) || (op_q == FN_INS_AT);
	assign wr1_last  = (((op_q == FN_INS_FRONT) || (op_q == FN_INS_END)) && empty) ||
		(((op_q == FN_DEL_FRONT) || (op_q == FN_DEL_END)) && one);

	assign rsp.valid = (state_q == S_RESP);
	assign rsp.data  = {sts_q, 6'(len_q), rhas_q, rval_q, rlast_q};
	assign req.ready = (state_q == S_IDLE);

	// decode of the held request
	status_t       dec_st;
	func_t         dec_fn;
	logic [CW-1:0] dec_steps;
	always_comb begin
		dec_st    = ST_OK;
		dec_fn    = func_q;
		dec_steps = '0;
		case (func_q)
			FN_INS_FRONT, FN_INS_END: if (full) dec_st = ST_FULL;
			FN_DEL_FRONT: if (empty) dec_st = ST_EMPTY;
			FN_DEL_END: begin
				if (empty) dec_st = ST_EMPTY;
				else if (!one) dec_steps = len_q - CW'(2);
			end
			FN_INS_AT: begin
				if (pos_q == 8'd0 || pos9 > len9 + 9'd1) dec_st = ST_BADPOS;
				else if (full) dec_st = ST_FULL;
				else if (pos_q == 8'd1) dec_fn = FN_INS_FRONT;
				else if (pos9 == len9 + 9'd1) dec_fn = FN_INS_END;
				else dec_steps = CW'(pos_q - 8'd2);
			end
			FN_DEL_AT: begin
				if (empty) dec_st = ST_EMPTY;
				else if (pos_q == 8'd0 || pos9 > len9) dec_st = ST_BADPOS;
				else if (pos_q == 8'd1) dec_fn = FN_DEL_FRONT;
				else if (pos9 == len9) begin
					dec_fn    = FN_DEL_END;
					dec_steps = len_q - CW'(2);
				end else dec_steps = CW'(pos_q - 8'd2);
			end
			FN_READ_ALL: if (empty) dec_st = ST_EMPTY;
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_INIT:   if (init_q == AW'(CAPACITY - 1)) state_nx = S_IDLE;
			S_IDLE:   if (req.valid) state_nx = S_DECIDE;
			S_DECIDE: begin
				if (dec_st != ST_OK) state_nx = S_RESP;
				else begin
					case (dec_fn)
						FN_INS_FRONT, FN_INS_END: state_nx = S_WR1;
						FN_INS_AT, FN_DEL_FRONT, FN_DEL_END, FN_DEL_AT: state_nx = S_WALK;
						FN_READ_ALL: state_nx = S_READ;
						default: state_nx = S_RESP;
					endcase
				end
			end
			S_WALK:   if (walk_done) state_nx = (op_q == FN_DEL_AT) ? S_VICT : S_WR1;
			S_VICT:   state_nx = S_WR1;
			S_WR1:    state_nx = wr1_last ? S_RESP : S_WR2;
			S_WR2:    state_nx = S_RESP;
			S_READ:   state_nx = S_EMIT;
			S_EMIT:   state_nx = S_RESP;
			S_RESP:   if (rsp.ready) state_nx = (rhas_q && !rlast_q) ? S_READ : S_IDLE;
			default:  state_nx = S_IDLE;
		endcase
	end

	// In S_WALK link_rd always holds link[p_q].
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_INIT;
			init_q    <= '0;
			front_q   <= '0;
			end_q     <= '0;
			free_q    <= '0;
			free_nx_q <= '0;
			p_q       <= '0;
			node_q    <= '0;
			nxt_q     <= '0;
			len_q     <= '0;
			steps_q   <= '0;
			w_q       <= '0;
			func_q    <= FN_NOP;
			op_q      <= FN_NOP;
			val_q     <= '0;
			pos_q     <= '0;
			emit_q    <= '0;
			sts_q     <= ST_OK;
			rhas_q    <= 1'b0;
			rlast_q   <= 1'b0;
			rval_q    <= '0;
		end else begin
			state_q <= state_nx;
			case (state_q)
				S_INIT: init_q <= init_q + 1'b1;
				S_IDLE: begin
					if (req.valid) begin
						func_q <= func_t'(req.data[42:40]);
						val_q  <= req.data[39:8];
						pos_q  <= req.data[7:0];
					end
				end
				S_DECIDE: begin
					op_q      <= dec_fn;
					sts_q     <= dec_st;
					rhas_q    <= 1'b0;
					rval_q    <= '0;
					rlast_q   <= 1'b1;
					free_nx_q <= link_rd;
					p_q       <= front_q;
					w_q       <= '0;
					steps_q   <= dec_steps;
					node_q    <= (dec_fn == FN_DEL_END) ? end_q : front_q;
					emit_q    <= '0;
				end
				S_WALK: begin
					if (!walk_done) begin
						p_q <= link_rd;
						w_q <= w_q + 1'b1;
					end else begin
						nxt_q <= link_rd;
						if (op_q == FN_DEL_AT) node_q <= link_rd;
					end
				end
				S_VICT: nxt_q <= link_rd;
				S_WR1: begin
					if (wr1_last) begin
						if (ins_op) begin
							front_q <= free_q;
							end_q   <= free_q;
							free_q  <= free_nx_q;
							len_q   <= len_q + 1'b1;
						end else begin
							free_q  <= node_q;
							front_q <= '0;
							end_q   <= '0;
							len_q   <= len_q - 1'b1;
						end
					end else if (op_q == FN_DEL_FRONT) front_q <= nxt_q;
					else if (op_q == FN_DEL_END) end_q <= p_q;
				end
				S_WR2: begin
					if (ins_op) begin
						if (op_q == FN_INS_FRONT) front_q <= free_q;
						if (op_q == FN_INS_END) end_q <= free_q;
						free_q <= free_nx_q;
						len_q  <= len_q + 1'b1;
					end else begin
						free_q <= node_q;
						len_q  <= len_q - 1'b1;
					end
				end
				S_EMIT: begin
					sts_q   <= ST_OK;
					rhas_q  <= 1'b1;
					rval_q  <= val_rd;
					rlast_q <= (7'(emit_q) + 7'd1 == rd_cnt);
					emit_q  <= emit_q + 1'b1;
					p_q     <= link_rd;
				end
				default: ;
			endcase
		end
	end

	// memory addressing and writes
	always_comb begin
		l_ra = p_q;
		v_ra = p_q;
		l_we = 1'b0; l_wa = p_q; l_wd = free_q;
		v_we = 1'b0; v_wa = free_q;
		case (state_q)
			S_INIT: begin
				l_we = 1'b1; l_wa = init_q;
				l_wd = (init_q == AW'(CAPACITY - 1)) ? '0 : init_q + 1'b1;
			end
			S_IDLE:   l_ra = free_q;
			S_DECIDE: l_ra = front_q;
			// follow the chain one link per cycle
			S_WALK:   l_ra = link_rd;
			S_WR1: begin
				case (op_q)
					FN_INS_FRONT, FN_INS_END: begin
						v_we = 1'b1;
						l_we = 1'b1; l_wa = free_q;
						l_wd = empty ? free_q : front_q;
					end
					FN_INS_AT: begin
						v_we = 1'b1;
						l_we = 1'b1; l_wa = free_q; l_wd = nxt_q;
					end
					FN_DEL_FRONT: begin
						l_we = 1'b1;
						if (one) begin
							l_wa = node_q; l_wd = free_q;
						end else begin
							l_wa = end_q; l_wd = nxt_q;
						end
					end
					FN_DEL_END: begin
						l_we = 1'b1;
						if (one) begin
							l_wa = node_q; l_wd = free_q;
						end else begin
							l_wa = p_q; l_wd = front_q;
						end
					end
					FN_DEL_AT: begin
						l_we = 1'b1; l_wa = p_q; l_wd = nxt_q;
					end
					default: ;
				endcase
			end
			S_WR2: begin
				l_we = 1'b1;
				case (op_q)
					FN_INS_FRONT, FN_INS_END: begin
						l_wa = end_q; l_wd = free_q;
					end
					FN_INS_AT: begin
						l_wa = p_q; l_wd = free_q;
					end
					default: begin
						l_wa = node_q; l_wd = free_q;
					end
				endcase
			end
			default: ;
		endcase
	end
endmodule

// ===== hdl/cle_checker.sv =====
module cle_checker import cle_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [41:0] rsp_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response changed while stalled");
	a_noreq: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready)
		else $error("request taken with response pending");
	a_elem_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data[33] |-> rsp_data[41:40] == ST_OK)
		else $error("element with error status");
	a_has: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data[33] |-> rsp_data[32:1] == '0 && rsp_data[0])
		else $error("value without element");
	a_rst: assert property (@(posedge clk) !arst_n |-> !rsp_valid)
		else $error("response during reset");
endmodule

bind circular_list_engine cle_checker u_cle_checker (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.rsp_data(rsp.data)
);

// ===== dv/tb_circular_list_engine.sv =====
module tb_circular_list_engine;
	import cle_pkg::*;

	localparam int unsigned CAP = 32;
	localparam int unsigned STALL_LIMIT = 5000;

	typedef struct {
		status_t     st;
		logic [5:0]  cnt;
		logic        has;
		logic [31:0] val;
		logic        last;
	} list_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cle_stream_if #(.W(43)) req_if();
	cle_stream_if #(.W(42)) rsp_if();

	circular_list_engine #(.CAPACITY(CAP)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if.sink),
		.rsp(rsp_if.source)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow copy of the list
	logic [31:0] node_val [CAP];
	logic [4:0]  node_next [CAP];
	logic [4:0]  head_node, tail_node, free_node;
	int unsigned list_len;

	list_result_t pending_results[$];
	int  errors = 0;
	int  accept_count = 0;
	bit  no_idle = 1'b0;
	bit  hold_rsp = 1'b0;

	function automatic bit idle_now();
		return !no_idle && ($urandom_range(0, 99) < 29);
	endfunction

	function automatic void shadow_reset();
		for (int i = 0; i < CAP; i++) begin
			node_next[i] = 5'(i + 1);
			node_val[i] = '0;
		end
		head_node = '0;
		tail_node = '0;
		free_node = '0;
		list_len = 0;
	endfunction

	function automatic logic [4:0] walk_links(int unsigned steps);
		logic [4:0] p;
		p = head_node;
		for (int unsigned i = 0; i < steps && i < CAP; i++)
			p = node_next[p];
		return p;
	endfunction

	function automatic logic [4:0] take_node(logic [31:0] v);
		logic [4:0] n;
		n = free_node;
		free_node = node_next[n];
		node_val[n] = v;
		return n;
	endfunction

	function automatic void give_node(logic [4:0] n);
		node_next[n] = free_node;
		free_node = n;
	endfunction

	function automatic void link_front(logic [31:0] v);
		logic [4:0] n;
		n = take_node(v);
		if (list_len == 0) begin
			head_node = n;
			tail_node = n;
			node_next[n] = n;
		end else begin
			node_next[n] = head_node;
			head_node = n;
			node_next[tail_node] = n;
		end
		list_len++;
	endfunction

	function automatic void link_end(logic [31:0] v);
		logic [4:0] n;
		n = take_node(v);
		if (list_len == 0) begin
			head_node = n;
			tail_node = n;
			node_next[n] = n;
		end else begin
			node_next[n] = head_node;
			node_next[tail_node] = n;
			tail_node = n;
		end
		list_len++;
	endfunction

	function automatic void unlink_front();
		logic [4:0] old;
		old = head_node;
		if (list_len == 1) begin
			give_node(old);
			head_node = '0;
			tail_node = '0;
		end else begin
			head_node = node_next[old];
			node_next[tail_node] = head_node;
			give_node(old);
		end
		list_len--;
	endfunction

	function automatic void unlink_end();
		logic [4:0] old, p;
		old = tail_node;
		if (list_len == 1) begin
			give_node(old);
			head_node = '0;
			tail_node = '0;
		end else begin
			p = walk_links(list_len - 2);
			tail_node = p;
			node_next[p] = head_node;
			give_node(old);
		end
		list_len--;
	endfunction

	function automatic void push_result(status_t st, logic has, logic [31:0] v, logic last);
		list_result_t r;
		r.st = st;
		r.cnt = 6'(list_len);
		r.has = has;
		r.val = v;
		r.last = last;
		pending_results.push_back(r);
	endfunction

	// apply one request to the shadow list and queue what the block must return
	function automatic void apply_request(func_t fn, logic [31:0] v, logic [7:0] pos);
		status_t st;
		bit full;
		logic [4:0] prev, n;
		int unsigned cnt;
		st = ST_OK;
		full = list_len >= CAP;
		case (fn)
			FN_INS_FRONT: if (full) st = ST_FULL; else link_front(v);
			FN_INS_END:   if (full) st = ST_FULL; else link_end(v);
			FN_DEL_FRONT: if (list_len == 0) st = ST_EMPTY; else unlink_front();
			FN_DEL_END:   if (list_len == 0) st = ST_EMPTY; else unlink_end();
			FN_INS_AT: begin
				if (pos < 1 || pos > list_len + 1) st = ST_BADPOS;
				else if (full) st = ST_FULL;
				else if (pos == 1) link_front(v);
				else if (pos == list_len + 1) link_end(v);
				else begin
					prev = walk_links(pos - 2);
					n = take_node(v);
					node_next[n] = node_next[prev];
					node_next[prev] = n;
					list_len++;
				end
			end
			FN_DEL_AT: begin
				if (list_len == 0) st = ST_EMPTY;
				else if (pos < 1 || pos > list_len) st = ST_BADPOS;
				else if (pos == 1) unlink_front();
				else if (pos == list_len) unlink_end();
				else begin
					prev = walk_links(pos - 2);
					n = node_next[prev];
					node_next[prev] = node_next[n];
					give_node(n);
					list_len--;
				end
			end
			FN_READ_ALL: begin
				if (list_len == 0) begin
					push_result(ST_EMPTY, 1'b0, '0, 1'b1);
				end else begin
					cnt = list_len < MAX_RESULTS ? list_len : MAX_RESULTS;
					n = head_node;
					for (int unsigned k = 0; k < cnt; k++) begin
						push_result(ST_OK, 1'b1, node_val[n], k + 1 == cnt);
						n = node_next[n];
					end
				end
				return;
			end
			default: ;
		endcase
		push_result(st, 1'b0, '0, 1'b1);
	endfunction

	task automatic send_request(func_t fn, logic [31:0] v, logic [7:0] pos);
		bit rdy;
		@(negedge clk);
		while (idle_now()) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data <= {fn, v, pos};
		forever begin
			#1 rdy = req_if.ready;
			@(posedge clk);
			if (rdy) break;
			@(negedge clk);
		end
		accept_count++;
		apply_request(fn, v, pos);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_if.valid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (2 * CAP + 8) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0;
			default: return $urandom;
		endcase
	endfunction

	// response side: decide ready at the falling edge, check at the rising edge
	initial begin
		bit hit;
		logic [41:0] d;
		list_result_t want;
		rsp_if.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			rsp_if.ready <= !hold_rsp && !idle_now();
			#1;
			hit = rsp_if.valid && rsp_if.ready;
			d = rsp_if.data;
			@(posedge clk);
			if (hit) begin
				accept_count++;
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result %h", $time, d);
				end else begin
					want = pending_results.pop_front();
					if (d[41:40] !== want.st) begin
						errors++;
						$display("%0t: status exp %0d got %0d", $time, want.st, d[41:40]);
					end
					if (d[39:34] !== want.cnt) begin
						errors++;
						$display("%0t: count exp %0d got %0d", $time, want.cnt, d[39:34]);
					end
					if (d[33] !== want.has) begin
						errors++;
						$display("%0t: has_element exp %0b got %0b", $time, want.has, d[33]);
					end
					if (d[32:1] !== want.val) begin
						errors++;
						$display("%0t: value exp %h got %h", $time, want.val, d[32:1]);
					end
					if (d[0] !== want.last) begin
						errors++;
						$display("%0t: last exp %0b got %0b", $time, want.last, d[0]);
					end
				end
			end
		end
	end

	// stall watchdog
	initial begin
		int idle_cycles;
		int seen;
		idle_cycles = 0;
		seen = 0;
		forever begin
			@(posedge clk);
			#1;
			if (accept_count != seen) begin
				seen = accept_count;
				idle_cycles = 0;
			end else if (++idle_cycles >= STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	task automatic test_corner_cases();
		send_request(FN_READ_ALL, '0, 8'd0);
		send_request(FN_DEL_FRONT, '0, 8'd0);
		send_request(FN_DEL_END, '0, 8'd0);
		send_request(FN_DEL_AT, '0, 8'd1);
		send_request(FN_INS_AT, 32'h1234_5678, 8'd0);
		send_request(FN_INS_AT, 32'h1234_5678, 8'd2);
		send_request(FN_INS_FRONT, 32'h7FFF_FFFF, 8'd0);
		send_request(FN_INS_END, 32'h8000_0000, 8'd255);
		send_request(FN_INS_AT, 32'hFFFF_FFFF, 8'd1);
		send_request(FN_INS_AT, 32'h0, 8'd4);
		send_request(FN_INS_AT, 32'hA5A5_5A5A, 8'd3);
		send_request(FN_READ_ALL, '0, 8'd0);
		send_request(FN_DEL_AT, '0, 8'd0);
		send_request(FN_DEL_AT, '0, 8'd6);
		send_request(FN_INS_AT, 32'h5555_AAAA, 8'd255);
		send_request(FN_DEL_AT, '0, 8'd3);
		send_request(FN_NOP, 32'hDEAD_BEEF, 8'd7);
		send_request(FN_DEL_AT, '0, 8'd4);
		send_request(FN_DEL_END, '0, 8'd0);
		send_request(FN_DEL_FRONT, '0, 8'd0);
		send_request(FN_READ_ALL, '0, 8'd0);
		send_request(FN_DEL_AT, '0, 8'd1);
		send_request(FN_READ_ALL, '0, 8'd0);
		wait_drained();
	endtask

	// fill the store while responses are held back, then probe the full cases
	task automatic test_full_store();
		fork
			begin
				hold_rsp = 1'b1;
				repeat (300) @(posedge clk);
				hold_rsp = 1'b0;
			end
		join_none
		no_idle = 1'b1;
		for (int i = 0; i < CAP; i++)
			send_request(i[0] ? FN_INS_END : FN_INS_FRONT, $urandom, 8'd0);
		no_idle = 1'b0;
		send_request(FN_INS_FRONT, 32'h1, 8'd0);
		send_request(FN_INS_END, 32'h2, 8'd0);
		send_request(FN_INS_AT, 32'h3, 8'd5);
		send_request(FN_INS_AT, 32'h4, 8'd34);
		send_request(FN_INS_AT, 32'h5, 8'd33);
		send_request(FN_READ_ALL, '0, 8'd0);
		send_request(FN_DEL_AT, '0, 8'd32);
		send_request(FN_DEL_AT, '0, 8'd33);
		send_request(FN_DEL_END, '0, 8'd0);
		wait_drained();
	endtask

	task automatic test_random_ops(int n_items);
		func_t fn;
		logic [7:0] pos;
		int unsigned roll;
		for (int i = 0; i < n_items; i++) begin
			no_idle = (i >= n_items / 3) && (i < n_items / 2);
			roll = $urandom_range(0, 99);
			if (roll < 3) fn = FN_NOP;
			else if (roll < 10) fn = FN_READ_ALL;
			else if (list_len < 4 || (list_len < 28 && roll < 55))
				fn = func_t'($urandom_range(0, 1) ? FN_INS_AT : $urandom_range(0, 1));
			else
				fn = func_t'($urandom_range(2, 3) + ($urandom_range(0, 1) ? 3 : 0));
			if (fn == FN_NOP) fn = ($urandom_range(0, 1)) ? FN_NOP : FN_DEL_AT;
			if ($urandom_range(0, 9) < 8)
				pos = 8'($urandom_range(1, list_len + 1));
			else
				pos = 8'($urandom_range(0, 255));
			send_request(fn, pick_value(), pos);
		end
		no_idle = 1'b0;
		wait_drained();
	endtask

	initial begin
		req_if.valid = 1'b0;
		req_if.data = '0;
		shadow_reset();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_corner_cases();
		test_full_store();
		test_random_ops(90);
		wait_drained();
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
hdl/cle_pkg.sv
hdl/cle_stream_if.sv
hdl/circular_list_engine.sv
hdl/cle_checker.sv
dv/tb_circular_list_engine.sv
